// File: src/fiu_pkg.sv
// ----------------------------------------------------------------------------
// fiu_pkg
// Shared types and constants of the flat index unravel block: field widths,
// result status codes, configuration register indexes, and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package fiu_pkg;

   localparam int IDX_W     = 32;
   localparam int ROW_W     = 32;
   localparam int NUM_DIMS  = 3;
   localparam int DIM_W     = 2;
   localparam int DIM_IDX_W = $clog2(NUM_DIMS);
   localparam int STATUS_W  = 3;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [STATUS_W-1:0] {
      ST_COORDS_OK    = 3'd0,
      ST_OUT_OF_RANGE = 3'd1,
      ST_ROW_DONE     = 3'd2,
      ST_ROW_FAILED   = 3'd3,
      ST_SKIPPED      = 3'd4
   } status_type;

   typedef enum logic {
      OP_APPEND = 1'b0,
      OP_FINISH = 1'b1
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DIM_COUNT = 3'd0,
      CSR_SIZE_0    = 3'd1,
      CSR_SIZE_1    = 3'd2,
      CSR_SIZE_2    = 3'd3,
      CSR_STRIDE_0  = 3'd4,
      CSR_STRIDE_1  = 3'd5,
      CSR_STRIDE_2  = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic accept;
      logic div_start;
      logic coord_wr;
      logic mark_fail;
      logic out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic needs_div;
      logic div_done;
      logic in_range;
      logic last_dim;
      logic out_free;
   } dp_stat_type;

endpackage

// File: src/fiu_req_if.sv
// ----------------------------------------------------------------------------
// fiu_req_if
// Request channel: one append or finish item per transfer.
// ----------------------------------------------------------------------------
interface fiu_req_if;
   import fiu_pkg::*;

   logic             valid;
   logic             ready;
   logic             opcode;
   logic [IDX_W-1:0] flat_index;

   modport source (output valid, output opcode, output flat_index, input ready);
   modport sink (input valid, input opcode, input flat_index, output ready);

endinterface

// File: src/fiu_rsp_if.sv
// ----------------------------------------------------------------------------
// fiu_rsp_if
// Response channel: status, row number and coordinates, one per transfer.
// ----------------------------------------------------------------------------
interface fiu_rsp_if;
   import fiu_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ROW_W-1:0]    row_number;
   logic [IDX_W-1:0]    coord_0;
   logic [IDX_W-1:0]    coord_1;
   logic [IDX_W-1:0]    coord_2;

   modport source (
      output valid, output status, output row_number,
      output coord_0, output coord_1, output coord_2,
      input ready
   );
   modport sink (
      input valid, input status, input row_number,
      input coord_0, input coord_1, input coord_2,
      output ready
   );

endinterface

// File: src/fiu_div.sv
// ----------------------------------------------------------------------------
// fiu_div
// Radix-2 restoring divider, one quotient bit per cycle. A zero divisor
// gives an all-ones quotient and the dividend as remainder.
// ----------------------------------------------------------------------------
module fiu_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [fiu_pkg::IDX_W-1:0] dividend,
   input  logic [fiu_pkg::IDX_W-1:0] divisor,
   output logic                      busy,
   output logic                      done,
   output logic [fiu_pkg::IDX_W-1:0] quotient,
   output logic [fiu_pkg::IDX_W-1:0] remainder
);
   import fiu_pkg::*;

   localparam int CNT_W = $clog2(IDX_W);

   logic [IDX_W-1:0] acc_ff;
   logic [IDX_W-1:0] rem_ff;
   logic [IDX_W-1:0] divisor_ff;
   logic [CNT_W-1:0] count_ff;
   logic             run_ff;
   logic             done_ff;
   logic [IDX_W:0]   shifted;
   logic [IDX_W:0]   diff;
   logic             qbit;

   assign shifted = {rem_ff, acc_ff[IDX_W-1]};
   assign diff    = shifted - {1'b0, divisor_ff};
   assign qbit    = ~diff[IDX_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff   <= 1'b1;
            count_ff <= '0;
         end else if (run_ff) begin
            count_ff <= count_ff + CNT_W'(1);
            if (count_ff == CNT_W'(IDX_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff     <= dividend;
         rem_ff     <= '0;
         divisor_ff <= divisor;
      end else if (run_ff) begin
         acc_ff <= {acc_ff[IDX_W-2:0], qbit};
         rem_ff <= qbit ? diff[IDX_W-1:0] : shifted[IDX_W-1:0];
      end
   end

   assign busy      = run_ff;
   assign done      = done_ff;
   assign quotient  = acc_ff;
   assign remainder = rem_ff;

endmodule

// File: src/fiu_ctrl.sv
// ----------------------------------------------------------------------------
// fiu_ctrl
// Sequencer for one item: accept; for appends in a good row, one divide and
// range check per dimension (stop on a miss); then response register load.
// ----------------------------------------------------------------------------
module fiu_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  fiu_pkg::dp_stat_type stat,
   output fiu_pkg::ctrl_cmd_type cmd
);
   import fiu_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_START = 5'b00010,
      S_WAIT  = 5'b00100,
      S_CHECK = 5'b01000,
      S_FINAL = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = stat.needs_div ? S_START : S_FINAL;
            end
         end
         S_START: begin
            cmd.div_start = 1'b1;
            state_in      = S_WAIT;
         end
         S_WAIT: begin
            if (stat.div_done) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.in_range) begin
               cmd.coord_wr = 1'b1;
               state_in     = stat.last_dim ? S_FINAL : S_START;
            end else begin
               cmd.mark_fail = 1'b1;
               state_in      = S_FINAL;
            end
         end
         S_FINAL: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: src/fiu_dpath.sv
// ----------------------------------------------------------------------------
// fiu_dpath
// Datapath: configuration registers, working index and coordinates, row
// state, shared divider and the response register.
// ----------------------------------------------------------------------------
module fiu_dpath #(
   parameter int MAX_DIMS   = 3,
   parameter int INDEX_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  fiu_pkg::ctrl_cmd_type         cmd,
   output fiu_pkg::dp_stat_type          stat,
   input  logic                          req_opcode,
   input  logic [fiu_pkg::IDX_W-1:0]     req_flat_index,
   input  logic                          csr_wr_en,
   input  logic [fiu_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [fiu_pkg::IDX_W-1:0]     csr_wdata,
   fiu_rsp_if.source                     rsp_if
);
   import fiu_pkg::*;

   localparam int DIM_CAP  = (MAX_DIMS < NUM_DIMS) ? MAX_DIMS : NUM_DIMS;
   localparam int IDX_KEEP = (INDEX_BITS < IDX_W) ? INDEX_BITS : IDX_W;
   localparam logic [IDX_W-1:0] IDX_MASK = {IDX_W{1'b1}} >> (IDX_W - IDX_KEEP);

   logic [DIM_W-1:0]     dim_count_ff;
   logic [IDX_W-1:0]     size_ff [NUM_DIMS];
   logic [IDX_W-1:0]     stride_ff [NUM_DIMS];
   logic [ROW_W-1:0]     row_counter_ff;
   logic [ROW_W-1:0]     row_counter_in;
   logic                 row_failed_ff;
   logic                 row_failed_in;
   logic [IDX_W-1:0]     idx_ff;
   logic [DIM_IDX_W-1:0] dim_ff;
   logic [IDX_W-1:0]     coord_ff [NUM_DIMS];
   status_type           status_ff;
   status_type           status_in;
   logic                 rsp_valid_ff;
   status_type           out_status_ff;
   logic [ROW_W-1:0]     out_row_ff;
   logic [IDX_W-1:0]     out_coord_ff [NUM_DIMS];
   logic [DIM_W-1:0]     dims_used;
   logic                 div_busy;
   logic                 div_done;
   logic [IDX_W-1:0]     div_q;
   logic [IDX_W-1:0]     div_r;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dim_count_ff <= DIM_W'(1);
         for (int i = 0; i < NUM_DIMS; i++) begin
            size_ff[i]   <= IDX_W'(1);
            stride_ff[i] <= IDX_W'(1);
         end
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DIM_COUNT: dim_count_ff <= csr_wdata[DIM_W-1:0];
            CSR_SIZE_0:    size_ff[0]   <= csr_wdata;
            CSR_SIZE_1:    size_ff[1]   <= csr_wdata;
            CSR_SIZE_2:    size_ff[2]   <= csr_wdata;
            CSR_STRIDE_0:  stride_ff[0] <= csr_wdata;
            CSR_STRIDE_1:  stride_ff[1] <= csr_wdata;
            CSR_STRIDE_2:  stride_ff[2] <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      dims_used = (dim_count_ff == '0) ? DIM_W'(1) : dim_count_ff;
      if (dims_used > DIM_W'(DIM_CAP)) begin
         dims_used = DIM_W'(DIM_CAP);
      end
   end

   fiu_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (idx_ff),
      .divisor   (stride_ff[dim_ff]),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   always_comb begin
      if (req_opcode == OP_FINISH) begin
         status_in = row_failed_ff ? ST_ROW_FAILED : ST_ROW_DONE;
      end else begin
         status_in = row_failed_ff ? ST_SKIPPED : ST_COORDS_OK;
      end
   end

   // working item
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         idx_ff    <= req_flat_index & IDX_MASK;
         dim_ff    <= '0;
         status_ff <= status_in;
         for (int i = 0; i < NUM_DIMS; i++) begin
            coord_ff[i] <= '0;
         end
      end else if (cmd.coord_wr) begin
         coord_ff[dim_ff] <= div_q;
         idx_ff           <= div_r;
         dim_ff           <= dim_ff + DIM_IDX_W'(1);
      end else if (cmd.mark_fail) begin
         status_ff <= ST_OUT_OF_RANGE;
      end
   end

   // row state, updated as the response is loaded
   always_comb begin
      row_counter_in = row_counter_ff;
      row_failed_in  = row_failed_ff;
      unique case (status_ff)
         ST_ROW_DONE: begin
            if (row_counter_ff != {ROW_W{1'b1}}) begin
               row_counter_in = row_counter_ff + ROW_W'(1);
            end
            row_failed_in = 1'b0;
         end
         ST_ROW_FAILED: begin
            row_failed_in = 1'b0;
         end
         ST_OUT_OF_RANGE: begin
            row_failed_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_counter_ff <= '0;
         row_failed_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (cmd.out_load) begin
            row_counter_ff <= row_counter_in;
            row_failed_ff  <= row_failed_in;
            rsp_valid_ff   <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_status_ff <= status_ff;
         out_row_ff    <= row_counter_ff;
         out_coord_ff  <= coord_ff;
      end
   end

   assign stat.needs_div = (req_opcode == OP_APPEND) && !row_failed_ff;
   assign stat.div_done  = div_done;
   assign stat.in_range  = div_q < size_ff[dim_ff];
   assign stat.last_dim  = dim_ff == DIM_IDX_W'(dims_used - DIM_W'(1));
   assign stat.out_free  = !rsp_valid_ff || rsp_if.ready;

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.status     = out_status_ff;
   assign rsp_if.row_number = out_row_ff;
   assign rsp_if.coord_0    = out_coord_ff[0];
   assign rsp_if.coord_1    = out_coord_ff[1];
   assign rsp_if.coord_2    = out_coord_ff[2];

   a_div_idle_on_start: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !div_busy)
      else $error("divider started while busy");

   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_if.ready))
      else $error("response register overwritten before transfer");

   a_row_stable: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$past(cmd.out_load)) |-> $stable(row_counter_ff))
      else $error("row counter moved without a response load");

   a_no_coords_on_row_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (out_status_ff == ST_ROW_DONE || out_status_ff == ST_ROW_FAILED
         || out_status_ff == ST_SKIPPED))
      |-> (out_coord_ff[0] == '0 && out_coord_ff[1] == '0 && out_coord_ff[2] == '0))
      else $error("coordinates present on a row or skip response");

endmodule

// File: src/flat_index_unravel.sv
// ----------------------------------------------------------------------------
// flat_index_unravel
// Converts flat element indices of a row into per-dimension coordinates by
// successive division by the dimension strides, with range checks and a
// saturating row counter.
// ----------------------------------------------------------------------------
// append item: per dimension divided, divide issue, one 32-step radix-2 divide
//   and range check (every dimension in use, or up to the one found out of range),
//   then the response load; finish and skipped items go straight to the load
// one item in flight at a time
// the response register lets the next request transfer while a response waits
// synchronous reset: row counter 0, row error clear, configuration registers 1
// ----------------------------------------------------------------------------
module flat_index_unravel #(
   parameter int MAX_DIMS   = 3,
   parameter int INDEX_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   fiu_req_if.sink                       req_if,
   fiu_rsp_if.source                     rsp_if,
   input  logic                          csr_wr_en,
   input  logic [fiu_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [fiu_pkg::IDX_W-1:0]     csr_wdata
);
   import fiu_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  stat;
   logic         req_ready;

   fiu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   fiu_dpath #(
      .MAX_DIMS   (MAX_DIMS),
      .INDEX_BITS (INDEX_BITS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_opcode     (req_if.opcode),
      .req_flat_index (req_if.flat_index),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_if         (rsp_if)
   );

   assign req_if.ready = req_ready;

endmodule

// File: verif/flat_index_unravel_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// flat_index_unravel_tb
// Self-checking bench for the flat index unravel block. A shadow copy of the
// row counter, row error flag and shape registers predicts the status, row
// number and coordinates of every request transfer. Responses are checked
// in order against those predictions. Directed rows cover reset values,
// range checks in each dimension and register corners. Random rows then run
// over several shapes under changing source and sink idle patterns.
// ----------------------------------------------------------------------------
module flat_index_unravel_tb;
   import fiu_pkg::*;

   localparam int QUIET_LIMIT  = 2000;
   localparam int SETTLE_BEATS = 4;
   localparam int TAIL_BEATS   = 120;
   localparam int SEG_COUNT    = 8;
   localparam int SEG_ITEMS    = 106;

   typedef struct packed {
      status_type       status;
      logic [ROW_W-1:0] row_number;
      logic [IDX_W-1:0] coord_0;
      logic [IDX_W-1:0] coord_1;
      logic [IDX_W-1:0] coord_2;
   } coord_result_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [IDX_W-1:0]     csr_wdata;

   fiu_req_if req_ch ();
   fiu_rsp_if rsp_ch ();

   flat_index_unravel u_top (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow state
   logic [DIM_W-1:0] dim_cnt;
   logic [IDX_W-1:0] dim_size [NUM_DIMS];
   logic [IDX_W-1:0] dim_stride [NUM_DIMS];
   logic [ROW_W-1:0] row_count;
   logic             row_err;

   coord_result_type expected_coords [$];
   int               mismatches;
   int               requests_sent;
   int               responses_seen;
   int               shapes_used;
   int               send_idle_pct;
   int               rsp_stall_pct;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int dims_in_use();
      int n;
      n = (dim_cnt == 0) ? 1 : int'(dim_cnt);
      if (n > NUM_DIMS)
         n = NUM_DIMS;
      return n;
   endfunction

   function automatic coord_result_type predict_unravel(opcode_type op,
                                                        logic [IDX_W-1:0] idx);
      coord_result_type res;
      logic [IDX_W-1:0] got [NUM_DIMS];
      logic [IDX_W-1:0] rem;
      logic [IDX_W-1:0] quo;
      int               d;
      bit               stop;
      for (d = 0; d < NUM_DIMS; d++)
         got[d] = '0;
      res.status     = ST_COORDS_OK;
      res.row_number = row_count;
      if (op == OP_FINISH) begin
         if (row_err) begin
            res.status = ST_ROW_FAILED;
         end else begin
            res.status = ST_ROW_DONE;
            if (row_count != '1)
               row_count = row_count + 1'b1;
         end
         row_err = 1'b0;
      end else if (row_err) begin
         res.status = ST_SKIPPED;
      end else begin
         rem  = idx;
         stop = 1'b0;
         for (d = 0; d < dims_in_use() && !stop; d++) begin
            quo = (dim_stride[d] == 0) ? '1 : rem / dim_stride[d];
            if (quo >= dim_size[d]) begin
               res.status = ST_OUT_OF_RANGE;
               row_err    = 1'b1;
               stop       = 1'b1;
            end else begin
               got[d] = quo;
               if (dim_stride[d] != 0)
                  rem = rem % dim_stride[d];
            end
         end
      end
      res.coord_0 = got[0];
      res.coord_1 = got[1];
      res.coord_2 = got[2];
      return res;
   endfunction

   // well-formed index from random coordinates; one dimension pushed to its
   // size when a bad index is wanted
   function automatic logic [IDX_W-1:0] pick_index(bit want_bad);
      logic [IDX_W-1:0] acc;
      logic [IDX_W-1:0] c;
      int               n;
      int               bad_dim;
      int               d;
      n       = dims_in_use();
      bad_dim = want_bad ? int'($urandom_range(n - 1, 0)) : -1;
      acc     = '0;
      for (d = 0; d < n; d++) begin
         if (d == bad_dim)
            c = dim_size[d];
         else if (dim_size[d] == 0)
            c = '0;
         else
            c = $urandom_range(dim_size[d] - 1, 0);
         acc = acc + c * dim_stride[d];
      end
      return acc;
   endfunction

   function void check_field(string name, logic [IDX_W-1:0] want, logic [IDX_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   task automatic write_reg(csr_index_type idx, logic [IDX_W-1:0] val);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_wr_en = 1'b0;
      unique case (idx)
         CSR_DIM_COUNT: dim_cnt = val[DIM_W-1:0];
         CSR_SIZE_0:    dim_size[0] = val;
         CSR_SIZE_1:    dim_size[1] = val;
         CSR_SIZE_2:    dim_size[2] = val;
         CSR_STRIDE_0:  dim_stride[0] = val;
         CSR_STRIDE_1:  dim_stride[1] = val;
         CSR_STRIDE_2:  dim_stride[2] = val;
         default: ;
      endcase
   endtask

   task automatic send_item(opcode_type op, logic [IDX_W-1:0] idx);
      @(negedge clock);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid      = 1'b1;
      req_ch.opcode     = op;
      req_ch.flat_index = idx;
      do
         @(posedge clock);
      while (!req_ch.ready);
      expected_coords.push_back(predict_unravel(op, idx));
      requests_sent++;
   endtask

   task automatic wait_drained(int beats);
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (expected_coords.size() != 0)
         @(posedge clock);
      repeat (beats) @(posedge clock);
   endtask

   task automatic write_shape(int dims, logic [IDX_W-1:0] s0, logic [IDX_W-1:0] s1,
                              logic [IDX_W-1:0] s2, logic [IDX_W-1:0] st0,
                              logic [IDX_W-1:0] st1, logic [IDX_W-1:0] st2);
      write_reg(CSR_DIM_COUNT, dims);
      write_reg(CSR_SIZE_0, s0);
      write_reg(CSR_SIZE_1, s1);
      write_reg(CSR_SIZE_2, s2);
      write_reg(CSR_STRIDE_0, st0);
      write_reg(CSR_STRIDE_1, st1);
      write_reg(CSR_STRIDE_2, st2);
      shapes_used++;
   endtask

   task automatic test_reset_state();
      send_item(OP_APPEND, 32'd0);
      send_item(OP_APPEND, 32'd0);
      send_item(OP_FINISH, 32'd0);
      send_item(OP_APPEND, 32'd1);
      send_item(OP_APPEND, 32'd5);
      send_item(OP_FINISH, 32'hFFFF_FFFF);
      send_item(OP_FINISH, 32'd0);
   endtask

   task automatic test_range_checks();
      wait_drained(SETTLE_BEATS);
      write_shape(3, 32'd4, 32'd3, 32'd5, 32'd30, 32'd6, 32'd1);
      send_item(OP_APPEND, 32'd0);
      send_item(OP_APPEND, 32'd106);
      send_item(OP_APPEND, 32'd120);
      send_item(OP_FINISH, 32'd0);
      send_item(OP_APPEND, 32'd24);
      send_item(OP_FINISH, 32'd0);
      send_item(OP_APPEND, 32'd5);
      send_item(OP_FINISH, 32'd0);
      send_item(OP_APPEND, 32'hFFFF_FFFF);
      send_item(OP_FINISH, 32'd0);
   endtask

   task automatic test_register_corners();
      // zero dimension count acts as one, widest size and stride
      wait_drained(SETTLE_BEATS);
      write_shape(0, 32'hFFFF_FFFF, 32'd1, 32'd1, 32'hFFFF_FFFF, 32'd1, 32'd1);
      send_item(OP_APPEND, 32'hFFFF_FFFF);
      send_item(OP_APPEND, 32'hFFFF_FFFE);
      send_item(OP_FINISH, 32'd0);
      // zero stride always out of range
      wait_drained(SETTLE_BEATS);
      write_reg(CSR_STRIDE_0, 32'd0);
      send_item(OP_APPEND, 32'd7);
      send_item(OP_FINISH, 32'd0);
      // zero size rejects everything
      wait_drained(SETTLE_BEATS);
      write_reg(CSR_SIZE_0, 32'd0);
      write_reg(CSR_STRIDE_0, 32'd1);
      send_item(OP_APPEND, 32'd0);
      send_item(OP_FINISH, 32'd0);
   endtask

   task automatic pick_shape(int kind);
      logic [IDX_W-1:0] s0, s1, s2, st0, st1, st2;
      int               dims;
      unique case (kind)
         0: begin
            dims = 3;
            s0   = $urandom_range(8, 1);
            s1   = $urandom_range(8, 1);
            s2   = $urandom_range(8, 1);
            st2  = 1;
            st1  = s2;
            st0  = s1 * s2;
         end
         1: begin
            dims = 2;
            s0   = $urandom_range(16'hFFFF, 1);
            s1   = $urandom_range(16'hFFFF, 1);
            st1  = 1;
            st0  = s1;
            s2   = $urandom;
            st2  = $urandom;
         end
         2: begin
            dims = $urandom_range(1, 0);
            s0   = $urandom_range(1, 0) ? 32'hFFFF_FFFF : $urandom_range(1000, 1);
            st0  = $urandom_range(64, 1);
            s1   = $urandom;
            s2   = $urandom;
            st1  = $urandom;
            st2  = $urandom;
         end
         default: begin
            dims = 3;
            s0   = $urandom;
            s1   = $urandom;
            s2   = $urandom;
            st0  = ($urandom_range(9, 0) == 0) ? 32'd0 : $urandom >> $urandom_range(31, 0);
            st1  = ($urandom_range(9, 0) == 0) ? 32'd0 : $urandom >> $urandom_range(31, 0);
            st2  = ($urandom_range(9, 0) == 0) ? 32'd0 : $urandom >> $urandom_range(31, 0);
         end
      endcase
      write_shape(dims, s0, s1, s2, st0, st1, st2);
   endtask

   task automatic test_random_rows();
      int seg;
      int seg_items;
      int row_len;
      bit paused;
      for (seg = 0; seg < SEG_COUNT; seg++) begin
         wait_drained(SETTLE_BEATS);
         unique case (seg % 4)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 83;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 83;
            end
            default: begin
               send_idle_pct = 7;
               rsp_stall_pct = 7;
            end
         endcase
         pick_shape((seg + seg / 4) % 4);
         seg_items = 0;
         paused    = 1'b0;
         while (seg_items < SEG_ITEMS) begin
            // halfway through each segment, hold the source until every response is back
            if (!paused && seg_items >= SEG_ITEMS / 2) begin
               wait_drained(0);
               paused = 1'b1;
            end
            row_len = $urandom_range(6, 0);
            repeat (row_len) begin
               if ($urandom_range(9, 0) == 0)
                  send_item(opcode_type'($urandom_range(1, 0)), $urandom);
               else
                  send_item(OP_APPEND, pick_index($urandom_range(19, 0) == 0));
               seg_items++;
            end
            send_item(OP_FINISH, $urandom);
            seg_items++;
         end
      end
   endtask

   always @(negedge clock) begin
      rsp_ch.ready = ($urandom_range(99, 0) >= rsp_stall_pct);
   end

   always @(posedge clock) begin : check_rsp
      coord_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         responses_seen++;
         if (expected_coords.size() == 0) begin
            $error("response transfer with nothing pending, status %0d", rsp_ch.status);
            mismatches++;
         end else begin
            want = expected_coords.pop_front();
            check_field("status", want.status, rsp_ch.status);
            check_field("row_number", want.row_number, rsp_ch.row_number);
            check_field("coord_0", want.coord_0, rsp_ch.coord_0);
            check_field("coord_1", want.coord_1, rsp_ch.coord_1);
            check_field("coord_2", want.coord_2, rsp_ch.coord_2);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      clock             = 1'b0;
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_index         = CSR_DIM_COUNT;
      csr_wdata         = '0;
      req_ch.valid      = 1'b0;
      req_ch.opcode     = OP_APPEND;
      req_ch.flat_index = '0;
      send_idle_pct     = 0;
      rsp_stall_pct     = 0;
      mismatches        = 0;
      requests_sent     = 0;
      responses_seen    = 0;
      shapes_used       = 0;
      dim_cnt           = 1;
      for (int d = 0; d < NUM_DIMS; d++) begin
         dim_size[d]   = 1;
         dim_stride[d] = 1;
      end
      row_count = '0;
      row_err   = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_state();
      test_range_checks();
      test_register_corners();
      test_random_rows();

      wait_drained(TAIL_BEATS);
      $display("covered %0d requests and %0d responses over %0d shapes", requests_sent,
               responses_seen, shapes_used);
      $display("idle patterns: none, source 83%%, sink 83%%, both 7%%; rows closed: %0d",
               row_count);
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// File: files.f
src/fiu_pkg.sv
src/fiu_req_if.sv
src/fiu_rsp_if.sv
src/fiu_div.sv
src/fiu_ctrl.sv
src/fiu_dpath.sv
src/flat_index_unravel.sv
verif/flat_index_unravel_tb.sv
